// File: rtl/bxt_pkg.sv
// ----------------------------------------------------------------------------
// bxt_pkg: shared types and constants of the binary trie maximum-xor unit
// Holds the trie geometry, the action and status codes, the controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bxt_pkg;

	// Trie geometry.
	localparam int VALUE_BITS = 32;
	localparam int POOL_NODES = 8192;
	localparam int PTR_W      = $clog2(POOL_NODES);
	localparam int CNT_W      = PTR_W + 1;
	localparam int NODE_W     = 2 * PTR_W;
	localparam int LVL_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	// Action codes carried by an input item.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Status codes carried by a result item.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_ALLOC,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic walk;
		logic alloc;
		logic publish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_walk;
		logic walk_end;
		logic go_alloc;
		logic alloc_last;
	} dpath_sts_t;

endpackage

// File: rtl/bxt_ctrl.sv
// ----------------------------------------------------------------------------
// bxt_ctrl: sequencer of the binary trie maximum-xor unit
// Steps each item through the trie walk, node allocation and result hand-off,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module bxt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bxt_pkg::dpath_sts_t sts,
	output bxt_pkg::ctrl_cmd_t  cmd
);

	bxt_pkg::state_t state_q;
	bxt_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	// The output register can take a new result when it is empty or drains now.
	assign slot_free = !out_valid_q || out_ready;

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bxt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bxt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_walk ? bxt_pkg::S_WALK : bxt_pkg::S_DONE;
				end
			end
			bxt_pkg::S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.go_alloc) begin
					state_d = bxt_pkg::S_ALLOC;
				end else if (sts.walk_end) begin
					state_d = bxt_pkg::S_DONE;
				end
			end
			bxt_pkg::S_ALLOC: begin
				cmd.alloc = 1'b1;
				if (sts.alloc_last) begin
					state_d = bxt_pkg::S_DONE;
				end
			end
			bxt_pkg::S_DONE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = bxt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bxt_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/bxt_dpath.sv
// ----------------------------------------------------------------------------
// bxt_dpath: node pool, root and walk logic of the binary trie maximum-xor unit
// Walks one trie level per cycle through the registered pool read, writes
// newly allocated nodes one per cycle and holds the result register.
// ----------------------------------------------------------------------------
module bxt_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bxt_pkg::ctrl_cmd_t                  cmd,
	output bxt_pkg::dpath_sts_t                 sts,
	input  logic [1:0]                          action,
	input  logic [bxt_pkg::VALUE_BITS-1:0]      value,
	output logic [bxt_pkg::VALUE_BITS-1:0]      max_xor,
	output logic [1:0]                          status
);

	localparam int PTR_W  = bxt_pkg::PTR_W;
	localparam int CNT_W  = bxt_pkg::CNT_W;
	localparam int NODE_W = bxt_pkg::NODE_W;
	localparam int LVL_W  = bxt_pkg::LVL_W;
	localparam int SUM_W  = CNT_W + 1;
	localparam int VB     = bxt_pkg::VALUE_BITS;

	// Node pool: each entry holds the one-child pointer above the zero-child pointer.
	logic [NODE_W-1:0] pool_mem [bxt_pkg::POOL_NODES];
	logic [NODE_W-1:0] rd_q;

	// Root and allocation count.
	logic [NODE_W-1:0] root_q;
	logic [CNT_W-1:0]  nodes_used_q;

	// Item and walk registers.
	bxt_pkg::action_t  act_q;
	logic [VB-1:0]     val_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              first_q;
	logic [PTR_W-1:0]  node_q;
	logic [VB-1:0]     acc_q;
	bxt_pkg::status_t  st_q;
	logic [PTR_W-1:0]  alloc_ptr_q;
	logic [LVL_W-1:0]  alloc_lvl_q;
	logic [VB-1:0]     max_xor_q;
	logic [1:0]        status_q;

	// Walk step signals.
	logic [NODE_W-1:0] ch;
	logic [PTR_W-1:0]  ch0;
	logic [PTR_W-1:0]  ch1;
	logic              bit_cur;
	logic [PTR_W-1:0]  c_same;
	logic [PTR_W-1:0]  c_opp;
	logic              last_lvl;
	logic [CNT_W-1:0]  need;
	logic [SUM_W-1:0]  need_sum;
	logic              full;
	logic [PTR_W-1:0]  new_idx;
	logic [NODE_W-1:0] patched;
	logic              step_go;
	logic [PTR_W-1:0]  step_ptr;
	logic              acc_set;
	logic              walk_end;
	logic              go_alloc;
	bxt_pkg::status_t  st_next;

	// Allocation and pool write signals.
	logic [PTR_W-1:0]  alloc_next;
	logic              alloc_bit;
	logic [NODE_W-1:0] alloc_data;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_wa;
	logic [NODE_W-1:0] mem_wd;

	// Children of the current node: the root for the top level, else the pool read.
	assign ch       = first_q ? root_q : rd_q;
	assign ch0      = ch[PTR_W-1:0];
	assign ch1      = ch[NODE_W-1:PTR_W];
	assign bit_cur  = val_q[lvl_q];
	assign c_same   = bit_cur ? ch1 : ch0;
	assign c_opp    = bit_cur ? ch0 : ch1;
	assign last_lvl = (lvl_q == '0);

	// A missing child at this level costs one node for this level and each below.
	assign need     = CNT_W'(lvl_q) + CNT_W'(1);
	assign need_sum = {1'b0, nodes_used_q} + {1'b0, need};
	assign full     = need_sum > SUM_W'(bxt_pkg::POOL_NODES);
	assign new_idx  = nodes_used_q[PTR_W-1:0];
	assign patched  = bit_cur ? {new_idx, ch0} : {ch1, new_idx};

	// One level of the insert or query walk.
	always_comb begin
		step_go  = 1'b0;
		step_ptr = '0;
		acc_set  = 1'b0;
		walk_end = 1'b0;
		go_alloc = 1'b0;
		st_next  = bxt_pkg::ST_OK;
		if (act_q == bxt_pkg::ACT_INSERT) begin
			if (c_same != '0) begin
				step_go  = 1'b1;
				step_ptr = c_same;
				walk_end = last_lvl;
			end else if (full) begin
				walk_end = 1'b1;
				st_next  = bxt_pkg::ST_FULL;
			end else begin
				go_alloc = 1'b1;
			end
		end else begin
			if (first_q && (ch == '0)) begin
				walk_end = 1'b1;
				st_next  = bxt_pkg::ST_EMPTY;
			end else if (c_opp != '0) begin
				step_go  = 1'b1;
				step_ptr = c_opp;
				acc_set  = 1'b1;
				walk_end = last_lvl;
			end else if (c_same != '0) begin
				step_go  = 1'b1;
				step_ptr = c_same;
				walk_end = last_lvl;
			end else begin
				walk_end = 1'b1;
			end
		end
	end

	// A new node links to the next new node along the value, the last one is a leaf.
	assign alloc_next = alloc_ptr_q + PTR_W'(1);
	assign alloc_bit  = val_q[alloc_lvl_q - LVL_W'(1)];
	always_comb begin
		if (alloc_lvl_q == '0) begin
			alloc_data = '0;
		end else if (alloc_bit) begin
			alloc_data = {alloc_next, {PTR_W{1'b0}}};
		end else begin
			alloc_data = {{PTR_W{1'b0}}, alloc_next};
		end
	end

	// Pool write: the patched parent at a miss below the root, then each new node.
	assign mem_we = (cmd.walk && go_alloc && !first_q) || cmd.alloc;
	assign mem_wa = cmd.alloc ? alloc_ptr_q : node_q;
	assign mem_wd = cmd.alloc ? alloc_data : patched;

	// Node pool with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_mem[mem_wa] <= mem_wd;
		end
		if (cmd.walk && step_go) begin
			rd_q <= pool_mem[step_ptr];
		end
	end

	// Root pointers and node count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q       <= '0;
			nodes_used_q <= CNT_W'(1);
		end else begin
			if (cmd.load && (bxt_pkg::action_t'(action) == bxt_pkg::ACT_CLEAR)) begin
				root_q       <= '0;
				nodes_used_q <= CNT_W'(1);
			end else if (cmd.walk && go_alloc) begin
				nodes_used_q <= need_sum[CNT_W-1:0];
				if (first_q) begin
					root_q <= patched;
				end
			end
		end
	end

	// Item, walk and allocation registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= bxt_pkg::action_t'(action);
			val_q   <= value;
			lvl_q   <= LVL_W'(VB - 1);
			first_q <= 1'b1;
			acc_q   <= '0;
			st_q    <= bxt_pkg::ST_OK;
		end else if (cmd.walk) begin
			st_q <= st_next;
			if (step_go) begin
				node_q  <= step_ptr;
				first_q <= 1'b0;
				lvl_q   <= lvl_q - LVL_W'(1);
			end
			if (acc_set) begin
				acc_q[lvl_q] <= 1'b1;
			end
			if (go_alloc) begin
				alloc_ptr_q <= new_idx;
				alloc_lvl_q <= lvl_q;
			end
		end else if (cmd.alloc) begin
			alloc_ptr_q <= alloc_next;
			alloc_lvl_q <= alloc_lvl_q - LVL_W'(1);
		end
	end

	// Result register, loaded as the item is handed to the output.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			max_xor_q <= acc_q;
			status_q  <= st_q;
		end
	end

	// Status toward the controller.
	assign sts.is_walk    = (bxt_pkg::action_t'(action) == bxt_pkg::ACT_INSERT) ||
	                        (bxt_pkg::action_t'(action) == bxt_pkg::ACT_QUERY);
	assign sts.walk_end   = walk_end;
	assign sts.go_alloc   = go_alloc;
	assign sts.alloc_last = (alloc_lvl_q == '0);

	assign max_xor = max_xor_q;
	assign status  = status_q;

endmodule

// File: rtl/binary_trie_max_xor_unit.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit: binary trie with maximum-xor queries
// Inserts values into a trie held in a node pool, answers maximum-xor
// queries against the stored values and clears the trie on request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, action, value) takes one item at a
//   time; the output channel (out_valid, out_ready, max_xor, status) returns
//   exactly one result item for each input item, in order.
//   A query walks one trie level per cycle through the registered pool read:
//   it is loaded, walks one level per value bit and then is handed off. An
//   insert walks until its first missing node and then writes one new node
//   per cycle; an insert of a known value or a rejected one ends at the
//   walk. A clear or an unused action goes from loading straight to the
//   hand-off.
//   The next item is accepted in the cycle after a result enters the output
//   register, even while that result still waits to be taken. If the
//   receiver stalls, the finished result of the following item waits inside
//   until the output register frees.
//   Reset empties the trie at once (root pointers null, one node counted);
//   the pool itself needs no clearing since every node is written when it is
//   allocated.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [bxt_pkg::VALUE_BITS-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bxt_pkg::VALUE_BITS-1:0] max_xor,
	output logic [1:0]                     status
);

	bxt_pkg::ctrl_cmd_t  cmd;
	bxt_pkg::dpath_sts_t sts;

	// Sequencer.
	bxt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Trie storage and walk.
	bxt_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.action  (action),
		.value   (value),
		.max_xor (max_xor),
		.status  (status)
	);

	// An accepted item keeps the input closed until its result is handed off.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready while an item is in progress");

	// Empty and rejected results carry a zero max_xor.
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(bxt_pkg::ST_OK)) |-> (max_xor == '0))
		else $error("nonzero max_xor on an empty or rejected result");

	// Only defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == 2'(bxt_pkg::ST_OK)) || (status == 2'(bxt_pkg::ST_EMPTY)) ||
		(status == 2'(bxt_pkg::ST_FULL)))
		else $error("undefined status code on a result");

endmodule
